[rtl/rv64ex_pkg.sv]
// Shared types, opcodes and constants of the RV64I integer execute core.
`default_nettype none

package rv64ex_pkg;

	localparam int XLEN     = 64;
	localparam int RF_DEPTH = 32;

	localparam logic [XLEN-1:0] RESET_PC_DEFAULT = 64'h0000_0000_8000_0000;

	// Major opcodes of the supported subset.
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [5:0] SHTOP_ARITH = 6'h10;

	// ALU funct3 codes.
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// Load and store funct3 codes.
	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;

	// Branch funct3 codes.
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_LOAD_REQ  = 3'd1,
		ST_STORE_REQ = 3'd2,
		ST_ILLEGAL   = 3'd3,
		ST_ORDER     = 3'd4
	} status_t;

	localparam logic ACT_EXEC = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

endpackage

`default_nettype wire

[rtl/rv64ex_if.sv]
// Request and response channel interfaces of the RV64I integer execute core.
`default_nettype none

interface rv64ex_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] instruction;
	logic [31:0] load_data;

	modport source (output valid, action, instruction, load_data, input ready);
	modport sink (input valid, action, instruction, load_data, output ready);
endinterface

interface rv64ex_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] mem_address;
	logic [1:0]  mem_size;
	logic [31:0] store_data;
	logic [63:0] next_pc;
	logic [4:0]  dest_reg;
	logic [63:0] dest_value;
	logic        dest_written;

	modport source (output valid, status, mem_address, mem_size, store_data, next_pc,
		dest_reg, dest_value, dest_written, input ready);
	modport sink (input valid, status, mem_address, mem_size, store_data, next_pc,
		dest_reg, dest_value, dest_written, output ready);
endinterface

`default_nettype wire

[rtl/rv64i_integer_execute_core.sv]
// RV64I subset execute core: register file, program counter and one-pass execute stage.
//
//  channel   dir  handshake     payload
//  req       in   valid/ready   action, instruction, load_data
//  rsp       out  valid/ready   status, mem_address, mem_size, store_data, next_pc,
//                               dest_reg, dest_value, dest_written
//  cfg       in   cfg_we        cfg_wdata (reset_pc)
//
// The register file read and the input register form the first stage from transfer in,
// execute and the result register the second. One item per cycle is sustained while rsp
// does not stall; a write back is forwarded to the read in the same edge.
// A stall on rsp holds the result register and then the input register, so req.ready drops.
// Reset clears the register file valid bits, the pc to 0x80000000 and the load tracking.
`default_nettype none

module rv64i_integer_execute_core import rv64ex_pkg::*; #(
	parameter int REG_COUNT = RF_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [XLEN-1:0]  cfg_wdata,
	rv64ex_req_if.sink            req,
	rv64ex_rsp_if.source          rsp
);

	localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

	// Register file storage and per-entry valid bits.
	logic [XLEN-1:0]      rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;
	logic                 rf_we;
	logic [4:0]           rf_waddr;
	logic [XLEN-1:0]      rf_wdata;

	// Architectural state.
	logic [XLEN-1:0] reset_pc_q;
	logic [XLEN-1:0] pc_q;
	logic            load_pending_q;
	logic [4:0]      load_dest_q;
	logic [2:0]      load_kind_q;

	// Stage 1: accepted item and its operands.
	logic            valid_s1;
	logic            action_s1;
	logic [31:0]     ins_s1;
	logic [31:0]     ld_s1;
	logic [XLEN-1:0] a_raw_s1;
	logic [XLEN-1:0] b_raw_s1;
	logic            a_ok_s1;
	logic            b_ok_s1;

	// Stage 2: result register.
	logic            valid_s2;
	status_t         status_s2;
	logic [XLEN-1:0] addr_s2;
	logic [1:0]      size_s2;
	logic [31:0]     sdata_s2;
	logic [XLEN-1:0] npc_s2;
	logic [4:0]      rd_s2;
	logic [XLEN-1:0] val_s2;
	logic            wr_s2;

	logic out_free;
	logic adv_s1;
	logic in_fire;

	logic [4:0] rs1_in;
	logic [4:0] rs2_in;
	logic       rs1_hit;
	logic       rs2_hit;

	assign out_free  = !valid_s2 || rsp.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign in_fire   = req.valid && req.ready;

	assign rs1_in  = req.instruction[19:15];
	assign rs2_in  = req.instruction[24:20];
	assign rs1_hit = rf_we && (rf_waddr == rs1_in);
	assign rs2_hit = rf_we && (rf_waddr == rs2_in);

	// The reset pc is held for software; the pc itself reloads its default on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_pc_q <= RESET_PC_DEFAULT;
		end else if (cfg_we) begin
			reset_pc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_waddr[IDX_W-1:0]] <= rf_wdata;
		end
		if (in_fire) begin
			a_raw_s1 <= rs1_hit ? rf_wdata : rf_mem[rs1_in[IDX_W-1:0]];
			b_raw_s1 <= rs2_hit ? rf_wdata : rf_mem[rs2_in[IDX_W-1:0]];
			action_s1 <= req.action;
			ins_s1    <= req.instruction;
			ld_s1     <= req.load_data;
		end
	end

	// An operand reads as zero for x0, an index beyond the file, or an entry never written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			valid_s1 <= 1'b0;
			a_ok_s1  <= 1'b0;
			b_ok_s1  <= 1'b0;
		end else begin
			if (rf_we) begin
				rf_vld_q[rf_waddr[IDX_W-1:0]] <= 1'b1;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
				a_ok_s1  <= (rs1_in != 5'd0) && ({1'b0, rs1_in} < REG_LIMIT) &&
					(rs1_hit || rf_vld_q[rs1_in[IDX_W-1:0]]);
				b_ok_s1  <= (rs2_in != 5'd0) && ({1'b0, rs2_in} < REG_LIMIT) &&
					(rs2_hit || rf_vld_q[rs2_in[IDX_W-1:0]]);
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Execute.
	logic [XLEN-1:0] a;
	logic [XLEN-1:0] b;
	logic [6:0]      opc;
	logic [2:0]      f3;
	logic [6:0]      f7;
	logic [4:0]      rd;
	logic [XLEN-1:0] imm_i;
	logic [XLEN-1:0] imm_s;
	logic [XLEN-1:0] imm_b;
	logic [XLEN-1:0] imm_u;
	logic            is_op;
	logic [XLEN-1:0] op_b;
	logic [5:0]      shamt;
	logic            alt;
	logic [XLEN-1:0] alu_val;
	logic            lt_s;
	logic            lt_u;
	logic [XLEN-1:0] agen;
	logic [XLEN-1:0] load_val;
	logic            take;

	status_t         res_status;
	logic [XLEN-1:0] res_addr;
	logic [1:0]      res_size;
	logic [31:0]     res_sdata;
	logic [XLEN-1:0] res_npc;
	logic [4:0]      res_rd;
	logic [XLEN-1:0] res_val;
	logic            res_wr;
	logic            wr_req;
	logic            nxt_pending;
	logic [4:0]      nxt_dest;
	logic [2:0]      nxt_kind;

	assign a   = a_ok_s1 ? a_raw_s1 : '0;
	assign b   = b_ok_s1 ? b_raw_s1 : '0;
	assign opc = ins_s1[6:0];
	assign f3  = ins_s1[14:12];
	assign f7  = ins_s1[31:25];
	assign rd  = ins_s1[11:7];

	assign imm_i = {{52{ins_s1[31]}}, ins_s1[31:20]};
	assign imm_s = {{52{ins_s1[31]}}, ins_s1[31:25], ins_s1[11:7]};
	assign imm_b = {{51{ins_s1[31]}}, ins_s1[31], ins_s1[7], ins_s1[30:25],
		ins_s1[11:8], 1'b0};
	assign imm_u = {{32{ins_s1[31]}}, ins_s1[31:12], 12'h000};

	// Only the immediate ALU ops take the immediate; register ops and branches compare rs2.
	assign is_op = (opc == OPC_OP);
	assign op_b  = (opc == OPC_OP_IMM) ? imm_i : b;
	assign shamt = is_op ? b[5:0] : ins_s1[25:20];
	assign alt   = is_op ? (f7 == F7_ALT) : ins_s1[30];
	assign lt_s  = $signed(a) < $signed(op_b);
	assign lt_u  = a < op_b;
	assign agen  = a + ((opc == OPC_STORE) ? imm_s : imm_i);

	always_comb begin
		case (f3)
			F3_ADD:  alu_val = (is_op && alt) ? (a - op_b) : (a + op_b);
			F3_SLL:  alu_val = a << shamt;
			F3_SLT:  alu_val = {63'd0, lt_s};
			F3_SLTU: alu_val = {63'd0, lt_u};
			F3_XOR:  alu_val = a ^ op_b;
			F3_SR:   alu_val = alt ? XLEN'($signed(a) >>> shamt) : (a >> shamt);
			F3_OR:   alu_val = a | op_b;
			F3_AND:  alu_val = a & op_b;
			default: alu_val = '0;
		endcase
	end

	always_comb begin
		case (load_kind_q)
			F3_LB:   load_val = {{56{ld_s1[7]}}, ld_s1[7:0]};
			F3_LH:   load_val = {{48{ld_s1[15]}}, ld_s1[15:0]};
			F3_LW:   load_val = {{32{ld_s1[31]}}, ld_s1};
			F3_LBU:  load_val = {56'd0, ld_s1[7:0]};
			default: load_val = {48'd0, ld_s1[15:0]};
		endcase
	end

	always_comb begin
		case (f3)
			F3_BEQ:  take = (a == b);
			F3_BNE:  take = (a != b);
			F3_BLT:  take = lt_s;
			F3_BGE:  take = !lt_s;
			F3_BLTU: take = lt_u;
			F3_BGEU: take = !lt_u;
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		res_status  = ST_DONE;
		res_addr    = '0;
		res_size    = 2'd0;
		res_sdata   = '0;
		res_npc     = pc_q + XLEN'(4);
		res_rd      = rd;
		res_val     = '0;
		wr_req      = 1'b0;
		nxt_pending = load_pending_q;
		nxt_dest    = load_dest_q;
		nxt_kind    = load_kind_q;

		if (action_s1 == ACT_LOAD) begin
			res_npc = pc_q;
			if (!load_pending_q) begin
				res_status = ST_ORDER;
			end else begin
				res_val     = load_val;
				res_rd      = load_dest_q;
				wr_req      = 1'b1;
				nxt_pending = 1'b0;
			end
		end else if (load_pending_q) begin
			res_status = ST_ORDER;
			res_npc    = pc_q;
		end else begin
			case (opc)
				OPC_OP: begin
					if (f7 != F7_BASE && !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
						res_status = ST_ILLEGAL;
					end else begin
						res_val = alu_val;
						wr_req  = 1'b1;
					end
				end
				OPC_OP_IMM: begin
					if ((f3 == F3_SLL && ins_s1[31:26] != 6'd0) ||
						(f3 == F3_SR && ins_s1[31:26] != 6'd0 &&
						ins_s1[31:26] != SHTOP_ARITH)) begin
						res_status = ST_ILLEGAL;
					end else begin
						res_val = alu_val;
						wr_req  = 1'b1;
					end
				end
				OPC_LOAD: begin
					if (f3 == 3'd3 || f3[2:1] == 2'b11) begin
						res_status = ST_ILLEGAL;
					end else begin
						res_status  = ST_LOAD_REQ;
						res_addr    = agen;
						res_size    = f3[1:0];
						nxt_pending = 1'b1;
						nxt_dest    = rd;
						nxt_kind    = f3;
					end
				end
				OPC_STORE: begin
					if (f3 > F3_LW) begin
						res_status = ST_ILLEGAL;
					end else begin
						res_status = ST_STORE_REQ;
						res_addr   = agen;
						res_size   = f3[1:0];
						case (f3)
							F3_LB:   res_sdata = {24'd0, b[7:0]};
							F3_LH:   res_sdata = {16'd0, b[15:0]};
							default: res_sdata = b[31:0];
						endcase
					end
				end
				OPC_BRANCH: begin
					if (f3 == 3'd2 || f3 == 3'd3) begin
						res_status = ST_ILLEGAL;
					end else if (take) begin
						res_npc = pc_q + imm_b;
					end
				end
				OPC_LUI: begin
					res_val = imm_u;
					wr_req  = 1'b1;
				end
				OPC_AUIPC: begin
					res_val = pc_q + imm_u;
					wr_req  = 1'b1;
				end
				default: begin
					res_status = ST_ILLEGAL;
				end
			endcase
			if (res_status == ST_ILLEGAL) begin
				res_npc = pc_q;
			end
		end

		res_wr = wr_req && (res_rd != 5'd0) && ({1'b0, res_rd} < REG_LIMIT);
		if (!res_wr) begin
			res_rd  = '0;
			res_val = '0;
		end
	end

	assign rf_we    = adv_s1 && res_wr;
	assign rf_waddr = res_rd;
	assign rf_wdata = res_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q           <= RESET_PC_DEFAULT;
			load_pending_q <= 1'b0;
			load_dest_q    <= '0;
			load_kind_q    <= '0;
			valid_s2       <= 1'b0;
		end else begin
			if (adv_s1) begin
				pc_q           <= res_npc;
				load_pending_q <= nxt_pending;
				load_dest_q    <= nxt_dest;
				load_kind_q    <= nxt_kind;
				valid_s2       <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= res_status;
			addr_s2   <= res_addr;
			size_s2   <= res_size;
			sdata_s2  <= res_sdata;
			npc_s2    <= res_npc;
			rd_s2     <= res_rd;
			val_s2    <= res_val;
			wr_s2     <= res_wr;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.status       = status_s2;
	assign rsp.mem_address  = addr_s2;
	assign rsp.mem_size     = size_s2;
	assign rsp.store_data   = sdata_s2;
	assign rsp.next_pc      = npc_s2;
	assign rsp.dest_reg     = rd_s2;
	assign rsp.dest_value   = val_s2;
	assign rsp.dest_written = wr_s2;

	// A load request always leaves a load pending for the next item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res_status == ST_LOAD_REQ) |=> load_pending_q)
		else $error("load request did not mark a pending load");

	// Out-of-order items (an exec with a load pending, load data with none) or illegal ones keep the pc.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (res_status == ST_ILLEGAL || res_status == ST_ORDER)) |=>
		(pc_q == $past(pc_q)))
		else $error("pc moved on an illegal or out-of-order item");

	// A register write is only reported together with a completed item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && wr_s2) |-> (status_s2 == ST_DONE && rd_s2 != 5'd0))
		else $error("register write reported with a request or error status");

	// The result register is never overwritten while it still waits for a transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp.ready) |-> !adv_s1)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
